>>> design/gcbst_pkg.sv
// gcbst_pkg: shared types and constants for the grid cell best-score table
// no dependencies
package gcbst_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned SCALE_W = 24;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned AXIS_W  = 16;   // stored width of one cell field
  localparam int unsigned ATOM_W  = 3 * AXIS_W;
  localparam int unsigned KEY_W   = 3 * ATOM_W;

  localparam logic [SCORE_W-1:0] ABSENT_SCORE = 32'd4259840000;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  // cell unit handshake
  typedef struct packed {
    logic start;
  } cell_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cell_sts_t;

endpackage

>>> design/gcbst_ram.sv
// gcbst_ram: generic single-port-write, single-read ram with registered read
// no dependencies
module gcbst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/gcbst_cell_unit.sv
// gcbst_cell_unit: turns nine coordinates into nine saturated cells, one per cycle
// through one shared 32x24 multiplier; depends on gcbst_pkg
module gcbst_cell_unit #(
  parameter int unsigned CELL_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  gcbst_pkg::cell_req_t                  req,
  input  logic [9*gcbst_pkg::COORD_W-1:0]       coords,
  input  logic [gcbst_pkg::SCALE_W-1:0]         scale,
  output gcbst_pkg::cell_sts_t                  sts,
  output logic [gcbst_pkg::KEY_W-1:0]           key
);

  localparam int unsigned PROD_W = gcbst_pkg::COORD_W + gcbst_pkg::SCALE_W;
  localparam logic [PROD_W-33:0] LIM = (PROD_W-32)'(1) << (CELL_BITS - 1);

  logic [3:0]                          idx_r, idx_nxt;
  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic                                pend_r, pend_nxt;   // product register holds a value
  logic                                neg_r;
  logic [3:0]                          pidx_r;
  logic [PROD_W-1:0]                   prod_r;
  logic [gcbst_pkg::KEY_W-1:0]         key_r;

  logic [gcbst_pkg::COORD_W-1:0]       c;
  logic                                neg;
  logic [gcbst_pkg::COORD_W-1:0]       mag;
  logic [PROD_W-33:0]                  q;
  logic [PROD_W-33:0]                  qs;
  logic [gcbst_pkg::AXIS_W-1:0]        axis_cell;

  always_comb begin
    c   = coords[idx_r*gcbst_pkg::COORD_W +: gcbst_pkg::COORD_W];
    neg = c[gcbst_pkg::COORD_W-1];
    mag = neg ? (~c + 1'b1) : c;   // most negative stays 0x80000000, as wanted
    q   = prod_r[PROD_W-1:32];
    if (neg_r) begin
      qs   = (q > LIM) ? LIM : q;
      qs   = ~qs + 1'b1;
    end else begin
      qs   = (q > LIM - 1'b1) ? (LIM - 1'b1) : q;
    end
    axis_cell = gcbst_pkg::AXIS_W'(qs[CELL_BITS-1:0]);
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    pend_nxt = 1'b0;
    done_nxt = 1'b0;
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (busy_r) begin
      if (idx_r != 4'd9) begin
        pend_nxt = 1'b1;
        idx_nxt  = idx_r + 1'b1;
      end else if (!pend_r) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      pend_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      pend_r <= pend_nxt;
      idx_r  <= idx_nxt;
    end
    prod_r <= PROD_W'(mag) * PROD_W'(scale);
    neg_r  <= neg;
    pidx_r <= idx_r;
    if (pend_r) begin
      key_r[pidx_r*gcbst_pkg::AXIS_W +: gcbst_pkg::AXIS_W] <= axis_cell;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign key      = key_r;

endmodule

>>> design/grid_cell_best_score_table.sv
// grid_cell_best_score_table: top level of the grid cell best-score table
// depends on gcbst_pkg, gcbst_cell_unit and gcbst_ram
//
// The block keeps one best (score, id) entry per nine-cell key built from three atom positions.
// Each transaction is handled alone: in_tready is low until the result has been taken. The nine
// coordinates go one a cycle through a shared multiplier, then an add or query scans every slot
// of the table through the key, score and id rams, one slot per cycle, drains the outstanding read
// and then makes its update. A clear and the unused function code skip the cell and scan steps.
// Slot valid bits live in flip-flops and reset clears them at once, so there is no clearing pass
// after reset. Each coordinate is scaled by cell_scale (Q8.16), truncated toward zero and saturated
// to a signed CELL_BITS cell. A query of an absent key returns score 65000.0.
module grid_cell_best_score_table #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned CELL_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [23:0]  cfg_wdata,       // cell_scale
  input  logic         in_tvalid,
  output logic         in_tready,
  // nitrogen_x, nitrogen_y, nitrogen_z, hydrogen_x, hydrogen_y, hydrogen_z,
  // carbon_x, carbon_y, carbon_z, score, entry_id
  input  logic [351:0] in_tdata,
  input  logic [1:0]   in_tuser,        // func
  output logic         out_tvalid,
  input  logic         out_tready,
  // found, stored_score, stored_id, replaced, table_full, 5 zero bits
  output logic [71:0]  out_tdata
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = 9 * gcbst_pkg::COORD_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CELLS, ST_SCAN, ST_DRAIN, ST_WRITE, ST_OUT
  } state_t;

  state_t                          state_r;
  logic [gcbst_pkg::SCALE_W-1:0]   scale_r;
  logic [1:0]                      func_r;
  logic [CW-1:0]                   coord_r;
  logic [gcbst_pkg::SCORE_W-1:0]   score_r;
  logic [gcbst_pkg::ID_W-1:0]      id_r;
  logic [TABLE_DEPTH-1:0]          valid_r;
  logic [AW:0]                     ptr_r;      // read address counter, one wider to hold the depth
  logic                            rd_v_r;     // read data is for a slot
  logic [AW-1:0]                   rd_slot_r;
  logic                            hit_r, free_v_r;
  logic [AW-1:0]                   hit_slot_r, free_slot_r;
  logic [gcbst_pkg::SCORE_W-1:0]   hit_score_r;
  logic [gcbst_pkg::ID_W-1:0]      hit_id_r;
  logic                            found_r, rep_r, full_r;
  logic [gcbst_pkg::SCORE_W-1:0]   s_out_r;
  logic [gcbst_pkg::ID_W-1:0]      id_out_r;
  logic                            wr_en_r;
  logic [AW-1:0]                   wr_addr_r;

  gcbst_pkg::cell_req_t            creq;
  gcbst_pkg::cell_sts_t            csts;
  logic [gcbst_pkg::KEY_W-1:0]     key;
  logic [gcbst_pkg::KEY_W-1:0]     rd_key;
  logic [gcbst_pkg::SCORE_W-1:0]   rd_score;
  logic [gcbst_pkg::ID_W-1:0]      rd_id;
  logic                            key_eq;
  logic                            wins;

  assign creq.start = (state_r == ST_CELLS) && !csts.busy && !csts.done;

  gcbst_cell_unit #(.CELL_BITS(CELL_BITS)) u_cells (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (creq),
    .coords (coord_r),
    .scale  (scale_r),
    .sts    (csts),
    .key    (key)
  );

  // key, score and id stores share the write port and scan address
  gcbst_ram #(.WIDTH(gcbst_pkg::KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk(clk), .wr_en(wr_en_r), .wr_addr(wr_addr_r), .wr_data(key),
    .rd_addr(ptr_r[AW-1:0]), .rd_data(rd_key)
  );
  gcbst_ram #(.WIDTH(gcbst_pkg::SCORE_W), .DEPTH(TABLE_DEPTH)) u_score_ram (
    .clk(clk), .wr_en(wr_en_r), .wr_addr(wr_addr_r), .wr_data(score_r),
    .rd_addr(ptr_r[AW-1:0]), .rd_data(rd_score)
  );
  gcbst_ram #(.WIDTH(gcbst_pkg::ID_W), .DEPTH(TABLE_DEPTH)) u_id_ram (
    .clk(clk), .wr_en(wr_en_r), .wr_addr(wr_addr_r), .wr_data(id_r),
    .rd_addr(ptr_r[AW-1:0]), .rd_data(rd_id)
  );

  assign key_eq = (rd_key == key);
  // compare against the held entry once the scan has found it
  assign wins   = (score_r < hit_score_r) ||
                  ((score_r == hit_score_r) && (id_r < hit_id_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      scale_r <= gcbst_pkg::SCALE_W'(65536);
      valid_r <= '0;
      rd_v_r  <= 1'b0;
      wr_en_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        scale_r <= cfg_wdata;
      end
      wr_en_r <= 1'b0;
      rd_v_r  <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            func_r  <= in_tuser;
            coord_r <= in_tdata[CW-1:0];
            score_r <= in_tdata[CW +: gcbst_pkg::SCORE_W];
            id_r    <= in_tdata[CW+gcbst_pkg::SCORE_W +: gcbst_pkg::ID_W];
            found_r <= 1'b0;
            rep_r   <= 1'b0;
            full_r  <= 1'b0;
            s_out_r <= gcbst_pkg::ABSENT_SCORE;
            id_out_r <= '0;
            hit_r   <= 1'b0;
            free_v_r <= 1'b0;
            ptr_r   <= '0;
            if (in_tuser == gcbst_pkg::FUNC_CLEAR) begin
              valid_r <= '0;
              state_r <= ST_OUT;
            end else if (in_tuser == gcbst_pkg::FUNC_NOP) begin
              state_r <= ST_OUT;
            end else begin
              state_r <= ST_CELLS;
            end
          end
        end
        ST_CELLS: begin
          if (csts.done) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // issue one read per cycle; the ram returns the data in the next cycle
          rd_v_r    <= 1'b1;
          rd_slot_r <= ptr_r[AW-1:0];
          if (ptr_r == (AW+1)'(TABLE_DEPTH - 1)) begin
            state_r <= ST_DRAIN;
          end
          ptr_r <= ptr_r + 1'b1;
        end
        ST_DRAIN: begin
          if (!rd_v_r) begin
            state_r <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (hit_r) begin
            found_r <= 1'b0 | 1'b1;
            if (func_r == gcbst_pkg::FUNC_ADD && wins) begin
              wr_en_r   <= 1'b1;
              wr_addr_r <= hit_slot_r;
              rep_r     <= 1'b1;
              s_out_r   <= score_r;
              id_out_r  <= id_r;
            end else begin
              s_out_r   <= hit_score_r;
              id_out_r  <= hit_id_r;
            end
          end else if (func_r == gcbst_pkg::FUNC_ADD) begin
            if (free_v_r) begin
              wr_en_r   <= 1'b1;
              wr_addr_r <= free_slot_r;
              valid_r[free_slot_r] <= 1'b1;
              rep_r     <= 1'b1;
              s_out_r   <= score_r;
              id_out_r  <= id_r;
            end else begin
              full_r    <= 1'b1;
            end
          end
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_tready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (rd_v_r) begin
        if (valid_r[rd_slot_r]) begin
          if (!hit_r && key_eq) begin
            hit_r       <= 1'b1;
            hit_slot_r  <= rd_slot_r;
            hit_score_r <= rd_score;
            hit_id_r    <= rd_id;
          end
        end else if (!free_v_r) begin
          free_v_r    <= 1'b1;
          free_slot_r <= rd_slot_r;
        end
      end
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {5'b00000, full_r, rep_r, id_out_r, s_out_r, found_r};

  // an add never both inserts and reports a full table
  assert property (@(posedge clk) disable iff (!rst_n) out_tvalid |-> !(rep_r && full_r))
    else $error("replaced and table_full both set");
  // only an add writes the table
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_en_r |-> (func_r == gcbst_pkg::FUNC_ADD))
    else $error("table write outside an add");
  // a clear leaves every slot empty
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == gcbst_pkg::FUNC_CLEAR) |=> (valid_r == '0))
    else $error("clear left valid slots");
  // table_full is never reported for a found key
  assert property (@(posedge clk) disable iff (!rst_n) (out_tvalid && full_r) |-> !found_r)
    else $error("table_full on a found key");

endmodule
